// ----- src/tcw_pkg.sv -----
// tcw_pkg: command codes, cell constants, cursor command struct and
// controller state type for the text console writer
// no dependencies
`default_nettype none

package tcw_pkg;

    // command codes of the input item
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    // character and cell constants
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0720;

    // cursor update request from the controller
    typedef struct packed {
        logic put;      // character written, advance one column
        logic newline;  // go to column 0 of the next row
        logic home;     // go to row 0, column 0
    } t_cur_cmd;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_COPY = 4'b0100,
        S_FILL = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- src/tcw_in_if.sv -----
// tcw_in_if: input channel of the text console writer
// valid/ready handshake with command, character and cell index
`default_nettype none

interface tcw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;

    modport source (output valid, command, char_code, cell_index, input ready);
    modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

`default_nettype wire

// ----- src/tcw_out_if.sv -----
// tcw_out_if: result channel of the text console writer
// valid/ready handshake with cursor position, cell word and scroll flag
`default_nettype none

interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_pos;
    logic [15:0] cell_word;
    logic        scrolled;

    modport source (output valid, cursor_pos, cell_word, scrolled, input ready);
    modport sink   (input valid, cursor_pos, cell_word, scrolled, output ready);
endinterface

`default_nettype wire

// ----- src/tcw_cursor.sv -----
// tcw_cursor: cursor row/column tracking with linear cell address
// depends on tcw_pkg
`default_nettype none

module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cur_cmd                           i_cmd,
    output logic [$clog2(ROWS*COLUMNS)-1:0]    o_addr,
    output logic [$clog2(ROWS*COLUMNS)-1:0]    o_next_addr,
    output logic                               o_scroll
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    logic [CW-1:0] r_col,  n_col;
    logic [RW-1:0] r_row,  n_row;
    logic [AW-1:0] r_base, n_base;
    logic          col_last;
    logic          row_last;
    logic          line_end;

    // next cursor position; the bottom row stays put on a scroll
    always_comb begin
        col_last = (r_col == CW'(COLUMNS - 1));
        row_last = (r_row == RW'(ROWS - 1));
        line_end = i_cmd.newline | (i_cmd.put & col_last);
        o_scroll = line_end & row_last;
        n_col    = r_col;
        n_row    = r_row;
        n_base   = r_base;
        if (i_cmd.home) begin
            n_col  = '0;
            n_row  = '0;
            n_base = '0;
        end else if (line_end) begin
            n_col = '0;
            if (!row_last) begin
                n_row  = r_row + RW'(1);
                n_base = r_base + AW'(COLUMNS);
            end
        end else if (i_cmd.put) begin
            n_col = r_col + CW'(1);
        end
    end

    assign o_addr      = r_base + AW'(r_col);
    assign o_next_addr = n_base + AW'(n_col);

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

    // cursor stays on the screen
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_addr) < CELLS)
        else $error("cursor address beyond the screen");

    // home request lands on the first cell
    a_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.home |=> (o_addr == '0))
        else $error("cursor not homed");

    // row base tracks the row
    a_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_base) == 32'(r_row) * COLUMNS))
        else $error("row base out of step with row");

endmodule

`default_nettype wire

// ----- src/text_console_writer.sv -----
// Text console writer: character-cell screen store with cursor, put, clear and read.
// Result: registered at accept for all but a read; a read result is registered in S_READ.
// Throughput: one put, newline or no-op item per cycle while the result register is free or
// being taken; a read holds input through S_READ, a scroll through the row copy plus blank
// row, and a clear through a full blanking sweep, as the cell memory is single-write.
// Reset: synchronous; a clearing pass of ROWS*COLUMNS cells (2000 by default) writes 0x0720.
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_cursor
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    // cell memory
    logic [15:0]   mem [CELLS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   r_mem_q;

    // control
    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [15:0]   r_fill_word, n_fill_word;
    logic          r_rd_ok;
    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic [7:0]    attr;
    logic          accept;
    logic          in_range;
    logic          copy_last;

    // cursor
    t_cur_cmd      cur_cmd;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] next_addr;
    logic          cur_scroll;

    // result register
    logic          r_out_valid;
    logic [10:0]   r_out_pos;
    logic [15:0]   r_out_cell;
    logic          r_out_scr;

    assign attr      = {r_bg, r_fg};
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign accept    = i_in.valid && i_in.ready;
    assign in_range  = (32'(i_in.cell_index) < CELLS);
    assign copy_last = (r_ptr == AW'(CELLS - COLUMNS - 1));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd7;
            r_bg <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: r_fg <= i_cfg_data;
                CFG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cursor requests
    always_comb begin
        cur_cmd         = '0;
        cur_cmd.put     = accept && (i_in.command == CMD_PUT) &&
                          (i_in.char_code != NEWLINE_CODE);
        cur_cmd.newline = accept && (i_in.command == CMD_PUT) &&
                          (i_in.char_code == NEWLINE_CODE);
        cur_cmd.home    = accept && (i_in.command == CMD_CLEAR);
    end

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cur_cmd),
        .o_addr      (cur_addr),
        .o_next_addr (next_addr),
        .o_scroll    (cur_scroll)
    );

    // sequencer and memory port control
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_fill_word = r_fill_word;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = r_fill_word;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.command)
                        CMD_PUT: begin
                            if (i_in.char_code != NEWLINE_CODE) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {attr, i_in.char_code};
                            end
                            if (cur_scroll) begin
                                mem_re      = 1'b1;
                                mem_raddr   = AW'(COLUMNS);
                                n_ptr       = '0;
                                n_fill_word = {attr, SPACE_CODE};
                                n_state     = S_COPY;
                            end
                        end
                        CMD_CLEAR: begin
                            n_ptr       = '0;
                            n_fill_word = {attr, SPACE_CODE};
                            n_state     = S_FILL;
                        end
                        CMD_READ: begin
                            mem_re    = in_range;
                            mem_raddr = in_range ? AW'(i_in.cell_index) : '0;
                            n_state   = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_COPY: begin
                // row r+1 moves to row r, one cell per cycle
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_mem_q;
                if (copy_last) begin
                    n_ptr   = AW'(CELLS - COLUMNS);
                    n_state = S_FILL;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + AW'(COLUMNS + 1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_ptr       <= '0;
            r_fill_word <= RESET_CELL;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_fill_word <= n_fill_word;
            if (accept) begin
                r_rd_ok <= in_range;
            end
        end
    end

    // cell memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // cell memory read port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (i_in.command != CMD_READ)) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_READ) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.command != CMD_READ)) begin
            r_out_pos  <= 11'(next_addr);
            r_out_cell <= '0;
            r_out_scr  <= cur_scroll;
        end else if (r_state == S_READ) begin
            r_out_pos  <= 11'(cur_addr);
            r_out_cell <= r_rd_ok ? r_mem_q : 16'h0000;
            r_out_scr  <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out_pos;
    assign o_out.cell_word  = r_out_cell;
    assign o_out.scrolled   = r_out_scr;

    // a read item goes through the read state
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.command == CMD_READ)) |=> (r_state == S_READ))
        else $error("read item did not wait for memory data");

    // a scrolling item starts the row copy
    a_scroll_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.command == CMD_PUT) && cur_scroll) |=> (r_state == S_COPY))
        else $error("scroll did not start the row copy");

    // the row copy hands over to blanking the bottom row
    a_copy_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && copy_last) |=>
            ((r_state == S_FILL) && (r_ptr == AW'(CELLS - COLUMNS))))
        else $error("row copy did not end in bottom row blanking");

    // the memory is never written while a read result is pending
    a_read_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !mem_we)
        else $error("memory written during read");

endmodule

`default_nettype wire
